[sv/bilinear_grid_sampler_macros.svh]
// Assertion macros used by the checker of the sampler.
`ifndef BILINEAR_GRID_SAMPLER_MACROS_SVH
`define BILINEAR_GRID_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bilinear_grid_sampler: check failed");

// Next-cycle implication, disabled while reset is low.
`define BGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bilinear_grid_sampler: check failed");

// Next-cycle implication that also runs during reset.
`define BGS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bilinear_grid_sampler: check failed");

`endif

[sv/bgs_pkg.sv]
package bgs_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int T_W         = FRAC_W + 1;
    localparam int ONE_Q16     = 1 << FRAC_W;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int LERP_W      = DATA_W + T_W + 1;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int SIZE_W      = 7;
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int IX_W        = $clog2((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS);

    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int PADDR_W     = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_ORIGIN,
        REG_X_LIMIT,
        REG_Y_ORIGIN,
        REG_Y_LIMIT,
        REG_X_INV_STEP,
        REG_Y_INV_STEP,
        REG_COLUMNS_USED,
        REG_ROWS_USED
    } t_reg_idx;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Load enables of the three axis stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_axis_en;

endpackage

[sv/bilinear_grid_sampler.sv]
// One request (load or query) per cycle unless stalled; the pipeline holds eight items.
// The four grid reads of a query come from four copies of the store, one read port each.
// Reset (synchronous, active low) clears every stage valid bit and sets the registers
// to their defaults; the grid store is not cleared and holds garbage until loaded.
module bilinear_grid_sampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic                                i_func,
    input  logic [bgs_pkg::STORE_AW-1:0]        i_sample_index,
    input  logic signed [bgs_pkg::DATA_W-1:0]   i_sample_value,
    input  logic signed [bgs_pkg::DATA_W-1:0]   i_point_x,
    input  logic signed [bgs_pkg::DATA_W-1:0]   i_point_y,
    // Response channel
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_ready,
    output logic signed [bgs_pkg::DATA_W-1:0]   o_distance,
    output logic                                o_outside,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bgs_pkg::PADDR_W-1:0]         paddr,
    input  logic [bgs_pkg::DATA_W-1:0]          pwdata,
    output logic [bgs_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic signed [bgs_pkg::DATA_W-1:0] r_x_origin;
    logic signed [bgs_pkg::DATA_W-1:0] r_x_limit;
    logic signed [bgs_pkg::DATA_W-1:0] r_y_origin;
    logic signed [bgs_pkg::DATA_W-1:0] r_y_limit;
    logic [bgs_pkg::DATA_W-1:0]        r_x_inv_step;
    logic [bgs_pkg::DATA_W-1:0]        r_y_inv_step;
    logic [bgs_pkg::SIZE_W-1:0]        r_columns_used;
    logic [bgs_pkg::SIZE_W-1:0]        r_rows_used;

    logic                              cfg_write;
    bgs_pkg::t_reg_idx                 cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = bgs_pkg::t_reg_idx'(paddr[bgs_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin     <= '0;
            r_x_limit      <= bgs_pkg::DATA_W'(bgs_pkg::ONE_Q16);
            r_y_origin     <= '0;
            r_y_limit      <= bgs_pkg::DATA_W'(bgs_pkg::ONE_Q16);
            r_x_inv_step   <= bgs_pkg::DATA_W'(bgs_pkg::ONE_Q16);
            r_y_inv_step   <= bgs_pkg::DATA_W'(bgs_pkg::ONE_Q16);
            r_columns_used <= bgs_pkg::SIZE_W'(2);
            r_rows_used    <= bgs_pkg::SIZE_W'(2);
        end else if (cfg_write) begin
            case (cfg_idx)
                bgs_pkg::REG_X_ORIGIN:     r_x_origin     <= $signed(pwdata);
                bgs_pkg::REG_X_LIMIT:      r_x_limit      <= $signed(pwdata);
                bgs_pkg::REG_Y_ORIGIN:     r_y_origin     <= $signed(pwdata);
                bgs_pkg::REG_Y_LIMIT:      r_y_limit      <= $signed(pwdata);
                bgs_pkg::REG_X_INV_STEP:   r_x_inv_step   <= pwdata;
                bgs_pkg::REG_Y_INV_STEP:   r_y_inv_step   <= pwdata;
                bgs_pkg::REG_COLUMNS_USED: r_columns_used <= pwdata[bgs_pkg::SIZE_W-1:0];
                bgs_pkg::REG_ROWS_USED:    r_rows_used    <= pwdata[bgs_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        case (cfg_idx)
            bgs_pkg::REG_X_ORIGIN:     prdata = r_x_origin;
            bgs_pkg::REG_X_LIMIT:      prdata = r_x_limit;
            bgs_pkg::REG_Y_ORIGIN:     prdata = r_y_origin;
            bgs_pkg::REG_Y_LIMIT:      prdata = r_y_limit;
            bgs_pkg::REG_X_INV_STEP:   prdata = r_x_inv_step;
            bgs_pkg::REG_Y_INV_STEP:   prdata = r_y_inv_step;
            bgs_pkg::REG_COLUMNS_USED: prdata = bgs_pkg::DATA_W'(r_columns_used);
            bgs_pkg::REG_ROWS_USED:    prdata = bgs_pkg::DATA_W'(r_rows_used);
            default:                   prdata = '0;
        endcase
    end

    // Grid size saturated to 2..max; the last cell index is size - 2. The user must change
    // registers only while the pipeline is empty to keep this static; no logic enforces it.
    logic [bgs_pkg::COL_W-1:0] cols;
    logic [bgs_pkg::ROW_W-1:0] rows;
    logic [bgs_pkg::IX_W-1:0]  x_top;
    logic [bgs_pkg::IX_W-1:0]  y_top;

    always_comb begin
        if (r_columns_used < bgs_pkg::SIZE_W'(2)) begin
            cols = bgs_pkg::COL_W'(2);
        end else if (int'(r_columns_used) > bgs_pkg::MAX_COLUMNS) begin
            cols = bgs_pkg::COL_W'(bgs_pkg::MAX_COLUMNS);
        end else begin
            cols = bgs_pkg::COL_W'(r_columns_used);
        end
        if (r_rows_used < bgs_pkg::SIZE_W'(2)) begin
            rows = bgs_pkg::ROW_W'(2);
        end else if (int'(r_rows_used) > bgs_pkg::MAX_ROWS) begin
            rows = bgs_pkg::ROW_W'(bgs_pkg::MAX_ROWS);
        end else begin
            rows = bgs_pkg::ROW_W'(r_rows_used);
        end
        x_top = bgs_pkg::IX_W'(cols - bgs_pkg::COL_W'(2));
        y_top = bgs_pkg::IX_W'(rows - bgs_pkg::ROW_W'(2));
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // A stage loads whenever it is empty or its successor loads, so
    // bubbles collapse; i_rsp_ready reaches o_req_ready combinationally.
    // Stages: 1 offset/bounds, 2 scale multiply, 3 cell locate,
    // 4 address gen, 5 store read, 6 x blend, 7 y blend, 8 response.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_rsp_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

    assign rdy8 = !r_rsp_valid || i_rsp_ready;
    assign rdy7 = !r_v7 || rdy8;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_req_ready = rdy1;

    // Stage payload carried beside the axis units
    bgs_pkg::t_func                    r_func1, r_func2, r_func3, r_func4;
    logic [bgs_pkg::STORE_AW-1:0]      r_sidx1, r_sidx2, r_sidx3;
    logic [bgs_pkg::DATA_W-1:0]        r_sval1, r_sval2, r_sval3, r_wdata4;
    logic [bgs_pkg::STORE_AW-1:0]      r_addr00, r_addr01, r_addr10, r_addr11;
    logic [bgs_pkg::T_W-1:0]           r_tx4, r_ty4, r_tx5, r_ty5, r_ty6;
    logic                              r_out4, r_out5, r_out6, r_out7;
    logic signed [bgs_pkg::DATA_W-1:0] r_distance;
    logic                              r_outside;

    // Valid bits: loads leave the pipeline once they pass the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_req_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4 && (r_func4 == bgs_pkg::FUNC_QUERY);
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
            if (rdy8) r_rsp_valid <= r_v7;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-3: per-axis offset, bounds test, scale, cell and fraction
    // ------------------------------------------------------------------
    bgs_pkg::t_axis_en          axis_en;
    logic [bgs_pkg::IX_W-1:0]   x_index, y_index;
    logic [bgs_pkg::T_W-1:0]    x_frac, y_frac;
    logic                       x_outside, y_outside;

    assign axis_en = '{s1: rdy1, s2: rdy2, s3: rdy3};

    bgs_axis u_axis_x (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_point    (i_point_x),
        .i_origin   (r_x_origin),
        .i_limit    (r_x_limit),
        .i_inv_step (r_x_inv_step),
        .i_top      (x_top),
        .o_index    (x_index),
        .o_frac     (x_frac),
        .o_outside  (x_outside)
    );

    bgs_axis u_axis_y (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_point    (i_point_y),
        .i_origin   (r_y_origin),
        .i_limit    (r_y_limit),
        .i_inv_step (r_y_inv_step),
        .i_top      (y_top),
        .o_index    (y_index),
        .o_frac     (y_frac),
        .o_outside  (y_outside)
    );

    // ------------------------------------------------------------------
    // Stage 4: row-major corner addresses, wrapped to the store depth.
    // A load uses the first address as its write address.
    // ------------------------------------------------------------------
    logic [bgs_pkg::IX_W+bgs_pkg::COL_W-1:0] n_row_base;
    logic [bgs_pkg::STORE_AW-1:0]            n_base;
    logic [bgs_pkg::STORE_AW-1:0]            n_cols;

    assign n_row_base = y_index * cols;
    assign n_cols     = bgs_pkg::STORE_AW'(cols);
    assign n_base     = bgs_pkg::STORE_AW'(n_row_base) + bgs_pkg::STORE_AW'(x_index);

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_func1 <= bgs_pkg::t_func'(i_func);
            r_sidx1 <= i_sample_index;
            r_sval1 <= i_sample_value;
        end
        if (rdy2) begin
            r_func2 <= r_func1;
            r_sidx2 <= r_sidx1;
            r_sval2 <= r_sval1;
        end
        if (rdy3) begin
            r_func3 <= r_func2;
            r_sidx3 <= r_sidx2;
            r_sval3 <= r_sval2;
        end
        if (rdy4) begin
            r_func4  <= r_func3;
            r_wdata4 <= r_sval3;
            r_tx4    <= x_frac;
            r_ty4    <= y_frac;
            r_out4   <= x_outside || y_outside;
            if (r_func3 == bgs_pkg::FUNC_LOAD) begin
                r_addr00 <= r_sidx3;
            end else begin
                r_addr00 <= n_base;
            end
            r_addr01 <= n_base + bgs_pkg::STORE_AW'(1);
            r_addr10 <= n_base + n_cols;
            r_addr11 <= n_base + n_cols + bgs_pkg::STORE_AW'(1);
        end
        if (rdy5) begin
            r_tx5  <= r_tx4;
            r_ty5  <= r_ty4;
            r_out5 <= r_out4;
        end
        if (rdy6) begin
            r_ty6  <= r_ty5;
            r_out6 <= r_out5;
        end
        if (rdy7) begin
            r_out7 <= r_out6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: four store copies, all written by a load as it leaves
    // stage 4, so any later query sees it. Reads advance with stage 5.
    // ------------------------------------------------------------------
    logic                       st_we;
    logic [bgs_pkg::DATA_W-1:0] rd00, rd01, rd10, rd11;

    assign st_we = rdy5 && r_v4 && (r_func4 == bgs_pkg::FUNC_LOAD);

    bgs_ram #(.WIDTH(bgs_pkg::DATA_W), .DEPTH(bgs_pkg::STORE_DEPTH)) u_store00 (
        .i_clk (i_clk), .i_we (st_we), .i_waddr (r_addr00), .i_wdata (r_wdata4),
        .i_re (rdy5), .i_raddr (r_addr00), .o_rdata (rd00)
    );

    bgs_ram #(.WIDTH(bgs_pkg::DATA_W), .DEPTH(bgs_pkg::STORE_DEPTH)) u_store01 (
        .i_clk (i_clk), .i_we (st_we), .i_waddr (r_addr00), .i_wdata (r_wdata4),
        .i_re (rdy5), .i_raddr (r_addr01), .o_rdata (rd01)
    );

    bgs_ram #(.WIDTH(bgs_pkg::DATA_W), .DEPTH(bgs_pkg::STORE_DEPTH)) u_store10 (
        .i_clk (i_clk), .i_we (st_we), .i_waddr (r_addr00), .i_wdata (r_wdata4),
        .i_re (rdy5), .i_raddr (r_addr10), .o_rdata (rd10)
    );

    bgs_ram #(.WIDTH(bgs_pkg::DATA_W), .DEPTH(bgs_pkg::STORE_DEPTH)) u_store11 (
        .i_clk (i_clk), .i_we (st_we), .i_waddr (r_addr00), .i_wdata (r_wdata4),
        .i_re (rdy5), .i_raddr (r_addr11), .o_rdata (rd11)
    );

    // ------------------------------------------------------------------
    // Stages 6-7: blend along x on both rows, then along y
    // ------------------------------------------------------------------
    logic signed [bgs_pkg::DATA_W-1:0] row0, row1, blend_xy;

    bgs_lerp u_lerp_row0 (
        .i_clk (i_clk), .i_en (rdy6),
        .i_a (rd00), .i_b (rd01), .i_t (r_tx5), .o_r (row0)
    );

    bgs_lerp u_lerp_row1 (
        .i_clk (i_clk), .i_en (rdy6),
        .i_a (rd10), .i_b (rd11), .i_t (r_tx5), .o_r (row1)
    );

    bgs_lerp u_lerp_col (
        .i_clk (i_clk), .i_en (rdy7),
        .i_a (row0), .i_b (row1), .i_t (r_ty6), .o_r (blend_xy)
    );

    // ------------------------------------------------------------------
    // Stage 8: response register; an outside point reads as 1.0.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy8) begin
            r_outside  <= r_out7;
            r_distance <= r_out7 ? bgs_pkg::DATA_W'(bgs_pkg::ONE_Q16) : blend_xy;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_distance  = r_distance;
    assign o_outside   = r_outside;

endmodule

[sv/bgs_ram.sv]
module bgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Hold read data while the read stage stalls.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bgs_axis.sv]
module bgs_axis (
    input  logic                              i_clk,
    input  bgs_pkg::t_axis_en                 i_en,
    input  logic signed [bgs_pkg::DATA_W-1:0] i_point,
    input  logic signed [bgs_pkg::DATA_W-1:0] i_origin,
    input  logic signed [bgs_pkg::DATA_W-1:0] i_limit,
    input  logic [bgs_pkg::DATA_W-1:0]        i_inv_step,
    input  logic [bgs_pkg::IX_W-1:0]          i_top,
    output logic [bgs_pkg::IX_W-1:0]          o_index,
    output logic [bgs_pkg::T_W-1:0]           o_frac,
    output logic                              o_outside
);

    logic signed [bgs_pkg::DATA_W:0]   n_off;
    logic [bgs_pkg::PROD_W-1:0]        n_prod;
    logic [bgs_pkg::DATA_W-1:0]        n_cell;

    logic [bgs_pkg::DATA_W-1:0]        r_off;
    logic                              r_out1;
    logic [bgs_pkg::PROD_W-1:0]        r_prod;
    logic                              r_out2;
    logic [bgs_pkg::IX_W-1:0]          r_index;
    logic [bgs_pkg::T_W-1:0]           r_frac;
    logic                              r_out3;

    // Offset from origin; non-negative and below 2^32 whenever inside.
    assign n_off  = {i_point[bgs_pkg::DATA_W-1], i_point}
                  - {i_origin[bgs_pkg::DATA_W-1], i_origin};
    assign n_prod = r_off * i_inv_step;
    assign n_cell = r_prod[bgs_pkg::PROD_W-1:bgs_pkg::DATA_W];

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_off  <= n_off[bgs_pkg::DATA_W-1:0];
            r_out1 <= (i_point < i_origin) || (i_point > i_limit);
        end
        if (i_en.s2) begin
            r_prod <= n_prod;
            r_out2 <= r_out1;
        end
        if (i_en.s3) begin
            r_out3 <= r_out2;
            // Past the last cell: pin to it, fraction saturates to one.
            if (n_cell > bgs_pkg::DATA_W'(i_top)) begin
                r_index <= i_top;
                r_frac  <= bgs_pkg::T_W'(bgs_pkg::ONE_Q16);
            end else begin
                r_index <= n_cell[bgs_pkg::IX_W-1:0];
                r_frac  <= {1'b0, r_prod[bgs_pkg::DATA_W-1:bgs_pkg::FRAC_W]};
            end
        end
    end

    assign o_index   = r_index;
    assign o_frac    = r_frac;
    assign o_outside = r_out3;

endmodule

[sv/bgs_lerp.sv]
module bgs_lerp (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [bgs_pkg::DATA_W-1:0] i_a,
    input  logic signed [bgs_pkg::DATA_W-1:0] i_b,
    input  logic [bgs_pkg::T_W-1:0]           i_t,
    output logic signed [bgs_pkg::DATA_W-1:0] o_r
);

    logic [bgs_pkg::T_W-1:0]           n_w;
    logic signed [bgs_pkg::LERP_W-1:0] n_a;
    logic signed [bgs_pkg::LERP_W-1:0] n_b;
    logic signed [bgs_pkg::LERP_W-1:0] n_wt;
    logic signed [bgs_pkg::LERP_W-1:0] n_t;
    logic signed [bgs_pkg::LERP_W-1:0] n_sum;
    logic signed [bgs_pkg::DATA_W-1:0] r_r;

    assign n_w   = bgs_pkg::T_W'(bgs_pkg::ONE_Q16) - i_t;
    assign n_a   = bgs_pkg::LERP_W'(i_a);
    assign n_b   = bgs_pkg::LERP_W'(i_b);
    assign n_wt  = $signed(bgs_pkg::LERP_W'(n_w));
    assign n_t   = $signed(bgs_pkg::LERP_W'(i_t));
    assign n_sum = n_a * n_wt + n_b * n_t;

    // Drop the fraction bits: an arithmetic shift floors toward minus infinity.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= $signed(n_sum[bgs_pkg::FRAC_W +: bgs_pkg::DATA_W]);
        end
    end

    assign o_r = r_r;

endmodule

[sv/bgs_checker.sv]
`include "bilinear_grid_sampler_macros.svh"

module bgs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_rsp_valid,
    input logic                              i_rsp_ready,
    input logic signed [bgs_pkg::DATA_W-1:0] o_distance,
    input logic                              o_outside,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [bgs_pkg::PADDR_W-1:0]       paddr,
    input logic [bgs_pkg::DATA_W-1:0]        pwdata,
    input logic [bgs_pkg::DATA_W-1:0]        prdata,
    input logic                              pready
);

    // Hold a stalled response.
    `BGS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready, o_rsp_valid && $stable(o_distance) && $stable(o_outside))

    // An outside point always answers 1.0.
    `BGS_ASSERT_NOW(a_outside_one, i_clk, i_rst_n, o_rsp_valid && o_outside, o_distance == bgs_pkg::DATA_W'(bgs_pkg::ONE_Q16))

    // Reset drops any response in flight.
    `BGS_ASSERT_ALWAYS_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_rsp_valid)

    // A written origin reads back on the following cycle.
    `BGS_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && (paddr[bgs_pkg::PADDR_W-1:2] == bgs_pkg::REG_X_ORIGIN), (paddr != $past(paddr)) || (prdata == $past(pwdata)))

endmodule

bind bilinear_grid_sampler bgs_checker u_bgs_checker (.*);
